[design/mtd_pkg.sv]
package mtd_pkg;

    // Byte codes
    localparam logic [7:0] DOT_CHAR       = 8'h2E;
    localparam logic [7:0] DASH_CHAR      = 8'h2D;
    localparam logic [7:0] SEPARATOR_CHAR = 8'h7C;
    localparam logic [7:0] UNKNOWN_CHAR   = 8'h21;

    // Default longest code; lookup ports are sized for the largest allowed value
    localparam int MAX_CODE_LENGTH_DEF = 6;
    localparam int LOOKUP_LEN_W        = 4;
    localparam int LOOKUP_PAT_W        = 8;
    localparam int CODE_W              = 6;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Class of one input byte
    typedef enum logic [1:0] {
        CLS_DOT,
        CLS_DASH,
        CLS_SEP,
        CLS_OTHER
    } sym_class_t;

    // One queued item, with its valid flag
    typedef struct packed {
        logic       valid;
        sym_class_t cls;
    } sym_item_t;

    // Code table: length, pattern (dot = 0, dash = 1, first symbol highest), character
    typedef struct packed {
        logic [LOOKUP_LEN_W-1:0] len;
        logic [CODE_W-1:0]       code;
        logic [7:0]              ch;
    } morse_entry_t;

    localparam int MORSE_TABLE_SIZE = 43;

    localparam morse_entry_t MORSE_TABLE [MORSE_TABLE_SIZE] = '{
        '{4'd2, 6'b000001, 8'h41}, // A .-
        '{4'd4, 6'b001000, 8'h42}, // B -...
        '{4'd4, 6'b001010, 8'h43}, // C -.-.
        '{4'd3, 6'b000100, 8'h44}, // D -..
        '{4'd1, 6'b000000, 8'h45}, // E .
        '{4'd4, 6'b000010, 8'h46}, // F ..-.
        '{4'd3, 6'b000110, 8'h47}, // G --.
        '{4'd4, 6'b000000, 8'h48}, // H ....
        '{4'd2, 6'b000000, 8'h49}, // I ..
        '{4'd4, 6'b000111, 8'h4A}, // J .---
        '{4'd3, 6'b000101, 8'h4B}, // K -.-
        '{4'd4, 6'b000100, 8'h4C}, // L .-..
        '{4'd2, 6'b000011, 8'h4D}, // M --
        '{4'd2, 6'b000010, 8'h4E}, // N -.
        '{4'd3, 6'b000111, 8'h4F}, // O ---
        '{4'd4, 6'b000110, 8'h50}, // P .--.
        '{4'd4, 6'b001101, 8'h51}, // Q --.-
        '{4'd3, 6'b000010, 8'h52}, // R .-.
        '{4'd3, 6'b000000, 8'h53}, // S ...
        '{4'd1, 6'b000001, 8'h54}, // T -
        '{4'd3, 6'b000001, 8'h55}, // U ..-
        '{4'd4, 6'b000001, 8'h56}, // V ...-
        '{4'd3, 6'b000011, 8'h57}, // W .--
        '{4'd4, 6'b001001, 8'h58}, // X -..-
        '{4'd4, 6'b001011, 8'h59}, // Y -.--
        '{4'd4, 6'b001100, 8'h5A}, // Z --..
        '{4'd5, 6'b011111, 8'h30}, // 0
        '{4'd5, 6'b001111, 8'h31}, // 1
        '{4'd5, 6'b000111, 8'h32}, // 2
        '{4'd5, 6'b000011, 8'h33}, // 3
        '{4'd5, 6'b000001, 8'h34}, // 4
        '{4'd5, 6'b000000, 8'h35}, // 5
        '{4'd5, 6'b010000, 8'h36}, // 6
        '{4'd5, 6'b011000, 8'h37}, // 7
        '{4'd5, 6'b011100, 8'h38}, // 8
        '{4'd5, 6'b011110, 8'h39}, // 9
        '{4'd6, 6'b010101, 8'h2E}, // full stop
        '{4'd6, 6'b110011, 8'h2C}, // comma
        '{4'd6, 6'b111000, 8'h3A}, // colon
        '{4'd6, 6'b001100, 8'h3F}, // question mark
        '{4'd6, 6'b100001, 8'h2D}, // hyphen
        '{4'd5, 6'b010010, 8'h2F}, // slash
        '{4'd6, 6'b011110, 8'h20}  // space
    };

    // Parallel match against every table entry; no match gives the unknown character
    function automatic logic [7:0] morse_lookup(input logic [LOOKUP_LEN_W-1:0] len,
                                                input logic [LOOKUP_PAT_W-1:0] pat);
        logic [7:0] ch;
        ch = UNKNOWN_CHAR;
        for (int e = 0; e < MORSE_TABLE_SIZE; e++) begin
            if (len == MORSE_TABLE[e].len &&
                pat == LOOKUP_PAT_W'(MORSE_TABLE[e].code)) begin
                ch = MORSE_TABLE[e].ch;
            end
        end
        return ch;
    endfunction

endpackage

[design/mtd_front.sv]
module mtd_front
    import mtd_pkg::*;
(
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       queue_full,
    output sym_item_t  push_item
);

    // Byte classification
    sym_class_t cls;

    always_comb begin
        priority if (s_in_byte == DOT_CHAR) begin
            cls = CLS_DOT;
        end else if (s_in_byte == DASH_CHAR) begin
            cls = CLS_DASH;
        end else if (s_in_byte == SEPARATOR_CHAR) begin
            cls = CLS_SEP;
        end else begin
            cls = CLS_OTHER;
        end
    end

    // Accept whenever the queue has room and reset is released
    assign s_ready         = ~queue_full & aresetn;
    assign push_item.valid = s_valid & ~queue_full & aresetn;
    assign push_item.cls   = cls;

endmodule

[design/mtd_queue.sv]
module mtd_queue
    import mtd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  sym_item_t push_item,
    output logic      full,
    input  logic      pop,
    output sym_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sym_class_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_pop;

    assign full           = (count_reg == CNT_W'(DEPTH));
    assign head_item.valid = (count_reg != '0);
    assign head_item.cls   = mem[rd_ptr_reg];
    assign do_pop          = pop & head_item.valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_item.valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push_item.valid, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push_item.valid) begin
            mem[wr_ptr_reg] <= push_item.cls;
        end
    end

endmodule

[design/mtd_back.sv]
module mtd_back
    import mtd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  sym_item_t  head_item,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char
);

    localparam int CNT_W = $clog2(MAX_CODE_LENGTH + 2);

    logic [CNT_W-1:0]           count_reg,   count_next;
    logic [MAX_CODE_LENGTH-1:0] pattern_reg, pattern_next;
    logic                       invalid_reg, invalid_next;
    logic                       m_valid_reg, m_valid_next;
    logic [7:0]                 m_char_reg,  m_char_next;
    logic [LOOKUP_LEN_W-1:0]    lookup_len;
    logic [LOOKUP_PAT_W-1:0]    lookup_pat;
    logic [7:0]                 lookup_char;
    logic                       out_free;

    // A separator may only be taken when the output register can accept it
    assign out_free = ~m_valid_reg | m_ready;
    assign pop      = head_item.valid & (out_free | (head_item.cls != CLS_SEP));

    // Widen the gathered code to the lookup's port width
    always_comb begin
        lookup_len = '0;
        lookup_pat = '0;
        lookup_len[CNT_W-1:0]           = count_reg;
        lookup_pat[MAX_CODE_LENGTH-1:0] = pattern_reg;
    end

    assign lookup_char = morse_lookup(lookup_len, lookup_pat);

    // Code accumulation and result generation
    always_comb begin
        count_next   = count_reg;
        pattern_next = pattern_reg;
        invalid_next = invalid_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_char_next  = m_char_reg;
        if (pop) begin
            unique case (head_item.cls)
                CLS_SEP: begin
                    if (count_reg != '0) begin
                        m_valid_next = 1'b1;
                        m_char_next  = (invalid_reg || count_reg > CNT_W'(MAX_CODE_LENGTH))
                                       ? UNKNOWN_CHAR : lookup_char;
                        count_next   = '0;
                        pattern_next = '0;
                        invalid_next = 1'b0;
                    end
                end
                CLS_DOT, CLS_DASH: begin
                    if (count_reg < CNT_W'(MAX_CODE_LENGTH)) begin
                        pattern_next = {pattern_reg[MAX_CODE_LENGTH-2:0],
                                        (head_item.cls == CLS_DASH)};
                    end
                    if (count_reg <= CNT_W'(MAX_CODE_LENGTH)) begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default: begin
                    invalid_next = 1'b1;
                    if (count_reg <= CNT_W'(MAX_CODE_LENGTH)) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pattern_reg <= '0;
            invalid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pattern_reg <= pattern_next;
            invalid_reg <= invalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output character register
    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;

endmodule

[design/morse_text_decoder_top.sv]
// Channel  | Ports                          | Transaction
// ---------+--------------------------------+-----------------------------------
// input    | s_valid, s_ready, s_in_byte    | one text byte ('.', '-', '|', other)
// output   | m_valid, m_ready, m_out_char   | one decoded character, '!' if unknown
//
// One byte is taken per cycle while the queue has room. A byte is first written into
// the queue; a separator's character is written into the output register when the
// separator is popped from the head of the queue.
// The rate is set by the code register update in the back end
// and the two-entry queue in front of it.
// Reset (aresetn low, synchronous) clears the code, the queue and the output valid;
// s_ready is low during reset.
// A stalled output holds a separator at the head of the queue; bytes behind it wait
// and s_ready drops once the queue is full.
module morse_text_decoder_top
    import mtd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char
);

    sym_item_t push_item;
    sym_item_t head_item;
    logic      queue_full;
    logic      pop;

    mtd_front u_front (
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .queue_full (queue_full),
        .push_item  (push_item)
    );

    mtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item)
    );

    mtd_back #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_item  (head_item),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char)
    );

endmodule
